// ----- hw/rtl/custom_radix_string_to_int_macros.svh -----
// assertion macros for the radix string-to-integer converter
`ifndef CUSTOM_RADIX_STRING_TO_INT_MACROS_SVH
`define CUSTOM_RADIX_STRING_TO_INT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define CRSTI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define CRSTI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/crsti_pkg.sv -----
// types and constants shared by the radix string-to-integer converter
`default_nettype none

package crsti_pkg;

	// alphabet geometry
	localparam int ALPHA_CHARS = 16;
	localparam int DIGIT_W     = 4;
	localparam int RADIX_W     = 5;
	localparam int LIMIT_W     = 8;
	localparam int ACC_W       = 32;

	// register map
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;
	localparam logic [1:0] REG_RADIX      = 2'd0;
	localparam logic [1:0] REG_ALPHA_LOW  = 2'd1;
	localparam logic [1:0] REG_ALPHA_HIGH = 2'd2;
	localparam logic [1:0] REG_CHAR_LIMIT = 2'd3;

	// register reset values
	localparam logic [RADIX_W-1:0] RADIX_RESET      = 5'd10;
	localparam logic [63:0]        ALPHA_LOW_RESET  = 64'h3736353433323130;
	localparam logic [63:0]        ALPHA_HIGH_RESET = 64'h0000000000003938;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 8'd0;

	// special characters
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CASE_BIT   = 8'h20;

	// magnitude saturation point, 2^31
	localparam logic [ACC_W-1:0] SAT_MAG = 32'h8000_0000;

	// result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_DIGIT = 2'd1;
	localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

	typedef struct packed {
		logic [7:0] text_char;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [1:0]         status;
	} out_item_t;

	typedef struct packed {
		logic               hit;
		logic [DIGIT_W-1:0] digit;
	} digit_match_t;

endpackage

`default_nettype wire

// ----- hw/rtl/crsti_digit_match.sv -----
// alphabet search: maps one character to its digit position, case folded
`default_nettype none

module crsti_digit_match (
	input  wire logic [7:0]                   text_char,
	input  wire logic [crsti_pkg::RADIX_W-1:0] eff_radix,
	input  wire logic [63:0]                  alpha_low,
	input  wire logic [63:0]                  alpha_high,
	output crsti_pkg::digit_match_t           match
);

	logic [7:0]   other_case;
	logic [127:0] alphabet;

	assign alphabet = {alpha_high, alpha_low};

	// opposite-case form of a letter
	always_comb begin
		other_case = text_char;
		if (text_char inside {[8'h61:8'h7A], [8'h41:8'h5A]}) begin
			other_case = text_char ^ crsti_pkg::CASE_BIT;
		end
	end

	// first position that matches, a sign character stops the search
	always_comb begin
		logic       done;
		logic [7:0] a;
		done  = 1'b0;
		match = '0;
		a     = '0;
		for (int i = 0; i < crsti_pkg::ALPHA_CHARS; i++) begin
			a = alphabet[8*i +: 8];
			if (!done && (crsti_pkg::RADIX_W'(i) < eff_radix)) begin
				if (a == crsti_pkg::CHAR_MINUS || a == crsti_pkg::CHAR_PLUS) begin
					done = 1'b1;
				end else if (a == text_char || a == other_case) begin
					done        = 1'b1;
					match.hit   = 1'b1;
					match.digit = crsti_pkg::DIGIT_W'(i);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/custom_radix_string_to_int.sv -----
// top level of the radix string-to-integer converter
// Usage:
//   in channel: one character per item (text_char, last_char), valid/ready.
//   out channel: one item (value, status) per string, after its last char.
//   APB port: radix at 0x00, alphabet chars 0..7 at 0x08, chars 8..15 at
//   0x10, char_limit at 0x18; 64-bit data, write only while idle.
// Path: a last character passes the input register, then the result
//   register, with the digit search over the 16 alphabet slots and one
//   32x5 multiply-add between the two; a stalled final character waits.
// Throughput: one character per cycle while no final character stalls.
// Reset: all string state clears, registers return to radix 10, alphabet
//   "0123456789", no char limit; both channels come up empty.
// Stall: while a result waits, non-final characters keep flowing; a final
//   character holds in the input register until the result slot frees,
//   and in_ready drops only then.
`default_nettype none

`include "custom_radix_string_to_int_macros.svh"

module custom_radix_string_to_int #(
	parameter int MAX_RADIX = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire crsti_pkg::in_item_t               in_item,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output crsti_pkg::out_item_t                   out_item,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [crsti_pkg::PADDR_W-1:0]     paddr,
	input  wire logic [crsti_pkg::PDATA_W-1:0]     pwdata,
	output logic [crsti_pkg::PDATA_W-1:0]          prdata,
	output logic                                   pready
);

	localparam int PROD_W = crsti_pkg::ACC_W + crsti_pkg::RADIX_W;
	localparam logic [crsti_pkg::RADIX_W-1:0] MAX_RADIX_V = crsti_pkg::RADIX_W'(MAX_RADIX);

	// configuration registers
	logic [crsti_pkg::RADIX_W-1:0] radix_q;
	logic [63:0]                   alpha_low_q;
	logic [63:0]                   alpha_high_q;
	logic [crsti_pkg::LIMIT_W-1:0] char_limit_q;

	// string state
	logic [crsti_pkg::ACC_W-1:0]   acc_q;
	logic                          negative_q;
	logic [crsti_pkg::LIMIT_W-1:0] chars_seen_q;
	logic                          bad_digit_q;
	logic                          overflowed_q;

	// input stage and result register
	logic                  valid_s1;
	crsti_pkg::in_item_t   item_s1;
	logic                  out_valid_q;
	crsti_pkg::out_item_t  out_item_q;

	logic                          cfg_write;
	logic [1:0]                    cfg_index;
	logic [crsti_pkg::RADIX_W-1:0] eff_radix;
	crsti_pkg::digit_match_t       match;
	logic                          out_free;
	logic                          adv_s1;
	logic                          finish;
	logic                          pos_zero;
	logic                          taken;
	logic                          is_lone;
	logic                          is_sign;
	logic                          do_digit;
	logic [PROD_W-1:0]             product;
	logic                          over;
	logic [crsti_pkg::ACC_W-1:0]   acc_nxt;
	logic                          negative_nxt;
	logic                          bad_nxt;
	logic                          ovf_nxt;
	crsti_pkg::out_item_t          result;

	// apb register port
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;
	assign cfg_index = paddr[4:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q      <= crsti_pkg::RADIX_RESET;
			alpha_low_q  <= crsti_pkg::ALPHA_LOW_RESET;
			alpha_high_q <= crsti_pkg::ALPHA_HIGH_RESET;
			char_limit_q <= crsti_pkg::LIMIT_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				crsti_pkg::REG_RADIX:      radix_q      <= pwdata[crsti_pkg::RADIX_W-1:0];
				crsti_pkg::REG_ALPHA_LOW:  alpha_low_q  <= pwdata;
				crsti_pkg::REG_ALPHA_HIGH: alpha_high_q <= pwdata;
				crsti_pkg::REG_CHAR_LIMIT: char_limit_q <= pwdata[crsti_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (cfg_index)
			crsti_pkg::REG_RADIX:      prdata = crsti_pkg::PDATA_W'(radix_q);
			crsti_pkg::REG_ALPHA_LOW:  prdata = alpha_low_q;
			crsti_pkg::REG_ALPHA_HIGH: prdata = alpha_high_q;
			crsti_pkg::REG_CHAR_LIMIT: prdata = crsti_pkg::PDATA_W'(char_limit_q);
			default:                   prdata = '0;
		endcase
	end

	// radix clamp
	assign eff_radix = (radix_q > MAX_RADIX_V) ? MAX_RADIX_V : radix_q;

	// flow control: only a final character needs the result slot
	assign out_free = !out_valid_q || out_ready;
	assign adv_s1   = valid_s1 && (!item_s1.last_char || out_free);
	assign finish   = adv_s1 && item_s1.last_char;
	assign in_ready = !valid_s1 || adv_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			item_s1 <= in_item;
		end
	end

	// digit lookup
	crsti_digit_match u_digit_match (
		.text_char  (item_s1.text_char),
		.eff_radix  (eff_radix),
		.alpha_low  (alpha_low_q),
		.alpha_high (alpha_high_q),
		.match      (match)
	);

	// character classification
	assign pos_zero = (chars_seen_q == '0);
	assign taken    = (char_limit_q == '0) || (chars_seen_q < char_limit_q);
	assign is_lone  = pos_zero && (item_s1.text_char == crsti_pkg::CHAR_ZERO) &&
		item_s1.last_char;
	assign is_sign  = pos_zero && (item_s1.text_char == crsti_pkg::CHAR_MINUS);
	assign do_digit = !is_sign && taken && !bad_digit_q;

	// multiply-add with saturation at 2^31
	assign product = PROD_W'(acc_q) * PROD_W'(eff_radix) + PROD_W'(match.digit);
	assign over    = product > PROD_W'(crsti_pkg::SAT_MAG);

	always_comb begin
		acc_nxt      = acc_q;
		negative_nxt = negative_q || is_sign;
		bad_nxt      = bad_digit_q || (do_digit && !match.hit);
		ovf_nxt      = overflowed_q || (do_digit && match.hit && over);
		if (do_digit && match.hit) begin
			acc_nxt = over ? crsti_pkg::SAT_MAG : product[crsti_pkg::ACC_W-1:0];
		end
	end

	// result of a finished string
	always_comb begin
		result.value  = '0;
		result.status = crsti_pkg::STATUS_OK;
		if (is_lone) begin
			result.status = crsti_pkg::STATUS_OK;
		end else if (bad_nxt) begin
			result.status = crsti_pkg::STATUS_BAD_DIGIT;
		end else if (ovf_nxt || (!negative_nxt && acc_nxt[crsti_pkg::ACC_W-1])) begin
			result.status = crsti_pkg::STATUS_OVERFLOW;
		end else if (negative_nxt) begin
			result.value = $signed(-acc_nxt);
		end else begin
			result.value = $signed(acc_nxt);
		end
	end

	// string state, cleared after each final character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			negative_q   <= 1'b0;
			chars_seen_q <= '0;
			bad_digit_q  <= 1'b0;
			overflowed_q <= 1'b0;
		end else if (finish) begin
			acc_q        <= '0;
			negative_q   <= 1'b0;
			chars_seen_q <= '0;
			bad_digit_q  <= 1'b0;
			overflowed_q <= 1'b0;
		end else if (adv_s1) begin
			acc_q        <= acc_nxt;
			negative_q   <= negative_nxt;
			bad_digit_q  <= bad_nxt;
			overflowed_q <= ovf_nxt;
			if (chars_seen_q != '1) begin
				chars_seen_q <= chars_seen_q + 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_item_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// checks
	`CRSTI_ASSERT_NOW(a_err_value_zero, out_valid && (out_item.status != crsti_pkg::STATUS_OK), out_item.value == 0, "error result carries nonzero value")
	`CRSTI_ASSERT_NOW(a_acc_saturated, 1'b1, acc_q <= crsti_pkg::SAT_MAG, "accumulator above saturation point")
	`CRSTI_ASSERT_NEXT(a_state_cleared, finish, (chars_seen_q == 0) && !bad_digit_q && !overflowed_q && (acc_q == 0), "string state not cleared after final character")
	`CRSTI_ASSERT_NOW(a_status_range, out_valid, out_item.status <= crsti_pkg::STATUS_OVERFLOW, "status code out of range")

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// testbench for the radix string-to-integer converter: directed and random strings, checked per result
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int RANDOM_ITEMS  = 1600;
	localparam int PHASE_ITEMS   = 100;
	localparam int SETTLE_CYCLES = 4;

	typedef logic [7:0] text_t[$];

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	crsti_pkg::in_item_t            in_item   = '0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	crsti_pkg::out_item_t           out_item;
	logic                           psel      = 1'b0;
	logic                           penable   = 1'b0;
	logic                           pwrite    = 1'b0;
	logic [crsti_pkg::PADDR_W-1:0]  paddr     = '0;
	logic [crsti_pkg::PDATA_W-1:0]  pwdata    = '0;
	logic [crsti_pkg::PDATA_W-1:0]  prdata;
	logic                           pready;

	// shadow copy of the registers
	logic [crsti_pkg::RADIX_W-1:0]  cfg_radix      = crsti_pkg::RADIX_RESET;
	logic [63:0]                    cfg_alpha_low  = crsti_pkg::ALPHA_LOW_RESET;
	logic [63:0]                    cfg_alpha_high = crsti_pkg::ALPHA_HIGH_RESET;
	logic [crsti_pkg::LIMIT_W-1:0]  cfg_limit      = crsti_pkg::LIMIT_RESET;

	// per-string parse state
	logic [32:0]         mag       = '0;
	logic                neg_seen  = 1'b0;
	logic [7:0]          pos_count = '0;
	logic                bad_seen  = 1'b0;
	logic                ovf_seen  = 1'b0;

	crsti_pkg::out_item_t parsed_q[$];
	int                  errors        = 0;
	int                  items_used    = 0;
	int                  cycles        = 0;
	int                  hold_cnt      = 0;
	int                  in_gap_max    = 0;
	int                  out_stall_max = 0;

	custom_radix_string_to_int #(
		.MAX_RADIX(crsti_pkg::ALPHA_CHARS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] alpha_at(int p);
		if (p < 8)
			return cfg_alpha_low[8*p +: 8];
		return cfg_alpha_high[8*(p-8) +: 8];
	endfunction

	function automatic int radix_used();
		return (int'(cfg_radix) > crsti_pkg::ALPHA_CHARS) ? crsti_pkg::ALPHA_CHARS :
			int'(cfg_radix);
	endfunction

	function automatic logic is_letter(logic [7:0] c);
		return ((c | crsti_pkg::CASE_BIT) >= "a") && ((c | crsti_pkg::CASE_BIT) <= "z");
	endfunction

	// alphabet position of a character, -1 on a miss; a sign in the alphabet stops the scan
	function automatic int digit_of(logic [7:0] c);
		logic [7:0] alt;
		logic [7:0] a;
		int         found;
		bit         done;
		alt   = is_letter(c) ? (c ^ crsti_pkg::CASE_BIT) : c;
		found = -1;
		done  = 1'b0;
		for (int i = 0; i < radix_used(); i++) begin
			a = alpha_at(i);
			if (!done) begin
				if (a == crsti_pkg::CHAR_MINUS || a == crsti_pkg::CHAR_PLUS) begin
					done = 1'b1;
				end else if (a == c || a == alt) begin
					found = i;
					done  = 1'b1;
				end
			end
		end
		return found;
	endfunction

	// advance the parse by one accepted character, queue the result on the last one
	task automatic parse_char(crsti_pkg::in_item_t it);
		int                   d;
		longint unsigned      grown;
		logic                 lone;
		logic                 taken;
		crsti_pkg::out_item_t res;
		items_used++;
		lone  = (pos_count == 0) && (it.text_char == crsti_pkg::CHAR_ZERO) && it.last_char;
		taken = (cfg_limit == 0) || (pos_count < cfg_limit);
		if (pos_count == 0 && it.text_char == crsti_pkg::CHAR_MINUS) begin
			neg_seen = 1'b1;
		end else if (taken && !bad_seen) begin
			d = digit_of(it.text_char);
			if (d < 0) begin
				bad_seen = 1'b1;
			end else begin
				grown = longint'(mag) * longint'(radix_used()) + longint'(d);
				if (grown > longint'(crsti_pkg::SAT_MAG)) begin
					ovf_seen = 1'b1;
					grown    = longint'(crsti_pkg::SAT_MAG);
				end
				mag = grown[32:0];
			end
		end
		if (pos_count != 8'hFF)
			pos_count++;

		if (it.last_char) begin
			res.value  = '0;
			res.status = crsti_pkg::STATUS_OK;
			if (lone) begin
				res.status = crsti_pkg::STATUS_OK;
			end else if (bad_seen) begin
				res.status = crsti_pkg::STATUS_BAD_DIGIT;
			end else if (ovf_seen || (!neg_seen && mag > 33'h0_7FFF_FFFF)) begin
				res.status = crsti_pkg::STATUS_OVERFLOW;
			end else if (neg_seen) begin
				res.value = -mag[31:0];
			end else begin
				res.value = mag[31:0];
			end
			parsed_q.push_back(res);
			mag       = '0;
			neg_seen  = 1'b0;
			pos_count = '0;
			bad_seen  = 1'b0;
			ovf_seen  = 1'b0;
		end
	endtask

	// predict on accepted characters, compare accepted results
	always @(posedge clk) begin
		crsti_pkg::out_item_t want;
		if (arst_n && in_valid && in_ready)
			parse_char(in_item);
		if (arst_n && out_valid && out_ready) begin
			if (parsed_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual value %0d status %0d",
					$time, out_item.value, out_item.status);
			end else begin
				want = parsed_q.pop_front();
				if (out_item.value !== want.value) begin
					errors++;
					$display("%0t: value mismatch, expected %0d, actual %0d",
						$time, want.value, out_item.value);
				end
				if (out_item.status !== want.status) begin
					errors++;
					$display("%0t: status mismatch, expected %0d, actual %0d",
						$time, want.status, out_item.status);
				end
			end
		end
	end

	// result side back-pressure, a fresh stall drawn after each result
	always @(posedge clk) begin
		if (out_valid && out_ready)
			hold_cnt = $urandom_range(0, out_stall_max);
		else if (hold_cnt > 0)
			hold_cnt--;
		out_ready <= (hold_cnt == 0);
	end

	// send one character, with a random gap before it
	task automatic send_char(input logic [7:0] c, input logic last);
		int                  gap;
		crsti_pkg::in_item_t item;
		gap            = $urandom_range(0, in_gap_max);
		item.text_char = c;
		item.last_char = last;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_text(input text_t s);
		for (int i = 0; i < s.size(); i++)
			send_char(s[i], i == s.size() - 1);
	endtask

	function automatic text_t chars_of(string s);
		text_t t;
		for (int i = 0; i < s.len(); i++)
			t.push_back(s[i]);
		return t;
	endfunction

	// stop sending and wait until every result is back
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (parsed_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write in a setup and an access phase, then the bus idles
	task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			crsti_pkg::REG_RADIX:      cfg_radix      = data[crsti_pkg::RADIX_W-1:0];
			crsti_pkg::REG_ALPHA_LOW:  cfg_alpha_low  = data;
			crsti_pkg::REG_ALPHA_HIGH: cfg_alpha_high = data;
			crsti_pkg::REG_CHAR_LIMIT: cfg_limit      = data[crsti_pkg::LIMIT_W-1:0];
			default:                   ;
		endcase
		@(posedge clk);
	endtask

	// write all registers while idle; alphabet bytes past its end are zero
	task automatic set_config(input int r, input text_t alpha, input int lim);
		logic [63:0] lo;
		logic [63:0] hi;
		lo = '0;
		hi = '0;
		for (int i = 0; i < alpha.size() && i < crsti_pkg::ALPHA_CHARS; i++) begin
			if (i < 8)
				lo[8*i +: 8] = alpha[i];
			else
				hi[8*(i-8) +: 8] = alpha[i];
		end
		settle();
		write_reg(crsti_pkg::REG_RADIX, 64'(r));
		write_reg(crsti_pkg::REG_ALPHA_LOW, lo);
		write_reg(crsti_pkg::REG_ALPHA_HIGH, hi);
		write_reg(crsti_pkg::REG_CHAR_LIMIT, 64'(lim));
	endtask

	function automatic logic [7:0] any_case(logic [7:0] c);
		if (is_letter(c) && $urandom_range(0, 1))
			return c ^ crsti_pkg::CASE_BIT;
		return c;
	endfunction

	// alphabet: mostly distinct symbols, sometimes a sign, a zero byte, repeats or pure noise
	function automatic text_t random_alphabet();
		text_t      pool;
		text_t      a;
		logic [7:0] tmp;
		int         j;
		int         kind;
		kind = $urandom_range(0, 9);
		if (kind >= 8) begin
			for (int i = 0; i < crsti_pkg::ALPHA_CHARS; i++)
				a.push_back(8'($urandom_range(0, 255)));
			return a;
		end
		pool = chars_of("0123456789abcdefghijklmnopqrstuvwxyz");
		for (int i = 0; i < crsti_pkg::ALPHA_CHARS; i++) begin
			j       = $urandom_range(i, pool.size() - 1);
			tmp     = pool[i];
			pool[i] = pool[j];
			pool[j] = tmp;
			a.push_back(any_case(pool[i]));
		end
		if (kind == 6)
			a[$urandom_range(0, crsti_pkg::ALPHA_CHARS - 1)] =
				$urandom_range(0, 1) ? crsti_pkg::CHAR_PLUS : crsti_pkg::CHAR_MINUS;
		if (kind == 7) begin
			a[$urandom_range(0, crsti_pkg::ALPHA_CHARS - 1)] = 8'h00;
			a[$urandom_range(0, crsti_pkg::ALPHA_CHARS - 1)] =
				a[$urandom_range(0, crsti_pkg::ALPHA_CHARS - 1)];
		end
		return a;
	endfunction

	function automatic int random_radix();
		case ($urandom_range(0, 7))
			0:       return 0;
			1:       return 1;
			2:       return 2;
			3:       return 10;
			4, 5:    return crsti_pkg::ALPHA_CHARS;
			6:       return $urandom_range(crsti_pkg::ALPHA_CHARS + 1, 31);
			default: return $urandom_range(0, 31);
		endcase
	endfunction

	function automatic int random_limit();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return 0;
			6, 7:             return $urandom_range(1, 12);
			8:                return $urandom_range(200, 255);
			default:          return $urandom_range(0, 255);
		endcase
	endfunction

	// mostly well-formed numbers in the current alphabet, plus boundary values and noise
	function automatic text_t random_string();
		text_t           s;
		int              kind;
		int              n;
		int              r;
		longint unsigned v;
		r    = radix_used();
		kind = $urandom_range(0, 99);
		if (kind < 70 && r > 0) begin
			if ($urandom_range(0, 2) == 0)
				s.push_back(crsti_pkg::CHAR_MINUS);
			if ($urandom_range(0, 7) == 0)
				s.push_back(crsti_pkg::CHAR_ZERO);
			n = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 7);
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 24) == 0)
					s.push_back(8'($urandom_range(0, 255)));
				else
					s.push_back(any_case(alpha_at($urandom_range(0, r - 1))));
			end
		end else if (kind < 85 && r >= 2) begin
			// encode a value near the 32-bit edges, a random 32-bit value or a small one
			case ($urandom_range(0, 4))
				0:       v = 64'h7FFF_FFFF;
				1:       v = 64'h8000_0000;
				2:       v = 64'h8000_0001;
				3:       v = 64'($urandom);
				default: v = 64'($urandom_range(0, 1000));
			endcase
			do begin
				s.push_front(any_case(alpha_at(int'(v % r))));
				v = v / r;
			end while (v != 0);
			if ($urandom_range(0, 1))
				s.push_front(crsti_pkg::CHAR_MINUS);
		end else if (kind < 95) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				s.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 99) begin
			case ($urandom_range(0, 3))
				0:       s = chars_of("0");
				1:       s = chars_of("-");
				2:       s = chars_of("-0");
				default: s = chars_of("00");
			endcase
		end else begin
			// long run up to and past the position counter's ceiling
			n = $urandom_range(250, 300);
			for (int i = 0; i < n; i++)
				s.push_back(r > 0 ? alpha_at($urandom_range(0, r - 1)) :
					8'(crsti_pkg::CHAR_ZERO));
		end
		return s;
	endfunction

	// registers at their reset values
	task automatic test_reset_defaults();
		send_text(chars_of("0"));
		send_text(chars_of("-"));
		send_text(chars_of("-12"));
		send_text(chars_of("7x"));
	endtask

	// largest and smallest values in hex, upper case digits, one past the top
	task automatic test_hex_extremes();
		set_config(crsti_pkg::ALPHA_CHARS, chars_of("0123456789abcdef"), 0);
		send_text(chars_of("7FFFFFFF"));
		send_text(chars_of("-80000000"));
		send_text(chars_of("80000000"));
	endtask

	// zero byte as a digit, case folding, a plus sign ending the search, oversized radix
	task automatic test_alphabet_search();
		text_t alpha;
		text_t s;
		alpha = chars_of("?aQ+z");
		alpha[0] = 8'h00;
		set_config(31, alpha, 0);
		s = '{8'h00, "A", "q"};
		send_text(s);
		send_text(chars_of("z"));
	endtask

	// characters past the limit are dropped, the sign counts as one
	task automatic test_char_limit();
		set_config(10, chars_of("0123456789"), 1);
		send_text(chars_of("-5"));
		set_config(10, chars_of("0123456789"), 3);
		send_text(chars_of("1234"));
	endtask

	// empty alphabet and a one-symbol alphabet
	task automatic test_tiny_radix();
		set_config(0, chars_of("0123456789"), 0);
		send_text(chars_of("5"));
		send_text(chars_of("0"));
		send_text(chars_of("-"));
		set_config(1, chars_of("0123456789"), 0);
		send_text(chars_of("00"));
		send_text(chars_of("01"));
	endtask

	// phases of random strings, each under a fresh configuration and idling mix
	task automatic test_random_strings();
		int goal;
		int phase_end;
		goal = items_used + RANDOM_ITEMS;
		while (items_used < goal) begin
			set_config(random_radix(), random_alphabet(), random_limit());
			case ($urandom_range(0, 3))
				0:       begin in_gap_max = 0;  out_stall_max = 0;  end
				1:       begin in_gap_max = 19; out_stall_max = 0;  end
				2:       begin in_gap_max = 0;  out_stall_max = 19; end
				default: begin in_gap_max = 19; out_stall_max = 19; end
			endcase
			phase_end = items_used + PHASE_ITEMS;
			while (items_used < phase_end)
				send_text(random_string());
		end
	endtask

	// reset, then the tests in turn
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_hex_extremes();
		test_alphabet_search();
		test_char_limit();
		test_tiny_radix();
		test_random_strings();
		settle();
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
